>>> sv/timer_capture_extender_defines.svh
// assertion macros shared by the timer capture extender checker
// no dependencies; the macros expect clk and rst_n in scope
`ifndef TIMER_CAPTURE_EXTENDER_DEFINES_SVH
`define TIMER_CAPTURE_EXTENDER_DEFINES_SVH

// checked only outside reset
`define TCE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TCE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/tce_pkg.sv
// types and constants for the timer capture extender
// no dependencies
`default_nettype none

package tce_pkg;

    localparam int CounterWidth = 16;
    localparam int TimeWidth    = 64;
    localparam int UpperWidth   = TimeWidth - CounterWidth;
    localparam int CountWidth   = 16;

    typedef enum logic
    {
        MODE_QUERY   = 1'b0,
        MODE_SERVICE = 1'b1
    } mode_t;

    typedef struct packed
    {
        logic        mode;
        logic        overflow_flag;
        logic        capture_flag;
        logic [15:0] capture_value;
        logic [15:0] counter_now;
    } evt_t;

    typedef struct packed
    {
        logic [TimeWidth-1:0]  time_now;
        logic [TimeWidth-1:0]  capture_time;
        logic [CountWidth-1:0] capture_count;
    } res_t;

endpackage

`default_nettype wire

>>> sv/timer_capture_extender.sv
// timer capture extender top level: 16-bit timer events to 64-bit times
// depends on tce_pkg
//
// usage:
//   evt channel (evt_valid, evt_stall, evt) carries one timer event per
//   transaction: a query (mode 0) or a service event (mode 1) with the
//   overflow flag, capture flag, captured value and current counter value.
//   res channel (res_valid, res_stall, res) returns one transaction per
//   event: extended current time, last capture time and capture count.
// timing: the result is registered, valid in the cycle after acceptance.
// throughput: 1 event per cycle if not stalled; the overflow count, capture
//   time and capture count update in the same cycle the event is taken,
//   and a single 48-bit incrementer sets the path into the result register.
// stall: while a result is held by res_stall, evt_stall is high; once the
//   result is taken a new event is accepted in that same cycle.
// reset: overflow count, capture time and capture count clear to zero and
//   no result is pending.
`default_nettype none

module timer_capture_extender
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          evt_valid,
    output      logic          evt_stall,
    input  wire tce_pkg::evt_t evt,
    output      logic          res_valid,
    input  wire logic          res_stall,
    output      tce_pkg::res_t res
);
    import tce_pkg::*;

    logic [UpperWidth-1:0]   upper_reg;
    logic [UpperWidth-1:0]   upper_next;
    logic [TimeWidth-1:0]    capture_reg;
    logic [TimeWidth-1:0]    capture_next;
    logic [CountWidth-1:0]   count_reg;
    logic [CountWidth-1:0]   count_next;
    logic                    res_valid_reg;
    logic                    res_valid_next;
    res_t                    res_reg;
    res_t                    res_next;
    logic                    accept;
    logic [UpperWidth-1:0]   upper_inc;
    logic [CounterWidth-1:0] cval;
    logic [CounterWidth-1:0] cnow;
    logic                    after_wrap;

    assign evt_stall = res_valid_reg && res_stall;
    assign accept    = evt_valid && !evt_stall;
    assign cval      = evt.capture_value[CounterWidth-1:0];
    assign cnow      = evt.counter_now[CounterWidth-1:0];
    assign upper_inc = upper_reg + UpperWidth'(1);
    assign after_wrap = evt.overflow_flag && !cval[CounterWidth-1];

    always_comb
    begin
        upper_next   = upper_reg;
        capture_next = capture_reg;
        count_next   = count_reg;
        if (accept && mode_t'(evt.mode) == MODE_SERVICE)
        begin
            if (evt.overflow_flag)
            begin
                upper_next = upper_inc;
            end
            if (!evt.overflow_flag || evt.capture_flag)
            begin
                capture_next = {(after_wrap ? upper_inc : upper_reg), cval};
                count_next   = count_reg + CountWidth'(1);
            end
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;
        if (accept)
        begin
            res_valid_next         = 1'b1;
            res_next.time_now      = {upper_next, cnow};
            res_next.capture_time  = capture_next;
            res_next.capture_count = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg     <= '0;
            capture_reg   <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            upper_reg     <= upper_next;
            capture_reg   <= capture_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

>>> sv/tce_checker.sv
// port-level checker for the timer capture extender, bound to the top level
// depends on tce_pkg and timer_capture_extender_defines.svh
`default_nettype none

`include "timer_capture_extender_defines.svh"

module tce_checker
(
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          evt_valid,
    input wire logic          evt_stall,
    input wire tce_pkg::evt_t evt,
    input wire logic          res_valid,
    input wire logic          res_stall,
    input wire tce_pkg::res_t res
);
    import tce_pkg::*;

    `TCE_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !res_valid, "result valid after reset")

    `TCE_ASSERT(a_result_follows, evt_valid && !evt_stall |=> res_valid, "transaction gave no result")

    `TCE_ASSERT(a_held_result, res_valid && res_stall |=> $stable(res), "stalled result changed")

    `TCE_ASSERT(a_query_keeps, evt_valid && !evt_stall && !evt.mode && res_valid |=>
        res.capture_count == $past(res.capture_count) &&
        res.capture_time == $past(res.capture_time) &&
        res.time_now[TimeWidth-1:CounterWidth] ==
        $past(res.time_now[TimeWidth-1:CounterWidth]), "query changed state")

    `TCE_ASSERT(a_capture_counts, evt_valid && !evt_stall && evt.mode && !evt.overflow_flag &&
        res_valid |=> res.capture_count == $past(res.capture_count) + CountWidth'(1),
        "capture count did not advance")

endmodule

bind timer_capture_extender tce_checker u_tce_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

`default_nettype wire
